/* hdl/rcm_pkg.sv */
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and constants of the rod cutting revenue engine.
// ----------------------------------------------------------------------------
package rcm_pkg;

  // Parameter defaults
  localparam int DEF_MAX_LENGTH = 64;
  localparam int DEF_PRICE_BITS = 16;

  // Fixed field widths
  localparam int PRICE_W   = 16;
  localparam int BEST_W    = 22;
  localparam int LEN_OUT_W = 7;
  localparam int ACC_W     = BEST_W + 1;
  localparam int OUT_DATA_W = 32;

  // Saturation limit of a stored best revenue
  localparam logic [BEST_W-1:0] BEST_LIMIT = {BEST_W{1'b1}};

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_FINISH
  } rcm_state_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic price_we;   // store the price of the new length
    logic best_we;    // store the best revenue of the new length
    logic rd_en;      // issue one read of both stores
    logic zero;       // this read pairs with the empty rod (best = 0)
    logic clear_acc;  // start a new maximum
  } rcm_ctl_t;

endpackage

/* hdl/rod_cutting_max_revenue.sv */
// ----------------------------------------------------------------------------
// rod_cutting_max_revenue
// Bottom-up rod cutting: one price per transaction, one best revenue back.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)               tlast     tuser
//  s_*      in   price[15:0]                      last      -
//  m_*      out  best_revenue[21:0], rod_length   done_res  overflow
//                [28:22], zero fill [31:29]
//
//  After a price for length L is accepted, the block reads both stores
//  once per cut through the single read port of each store, then passes
//  the drain and finish states and returns to idle, where it takes the
//  next price. An ignored price goes through finish and idle only.
//  The result sits in an output register; the finish state waits while a
//  previous result is still unaccepted. Reset clears the length counter and
//  control state only; the stores need no clearing.
// ----------------------------------------------------------------------------
module rod_cutting_max_revenue #(
  parameter int MAX_LENGTH = rcm_pkg::DEF_MAX_LENGTH,
  parameter int PRICE_BITS = rcm_pkg::DEF_PRICE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // price[15:0]
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // best_revenue[21:0], rod_length[28:22], zero [31:29]
  output logic        m_tlast,   // done_res
  output logic        m_tuser    // overflow
);

  localparam int IW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LW = $clog2(MAX_LENGTH + 1);

  rcm_pkg::rcm_state_t state, state_next;
  rcm_pkg::rcm_ctl_t   ctl;

  logic [LW-1:0] count;
  logic [LW-1:0] cur_len;
  logic [IW-1:0] k;
  logic          ovf;
  logic          done;

  logic          accept;
  logic          full;
  logic          out_free;
  logic [IW-1:0] last_k;
  logic [IW-1:0] best_base;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_best_addr;
  logic [rcm_pkg::BEST_W-1:0] best;

  assign accept    = s_tvalid && s_tready;
  assign full      = (count >= LW'(MAX_LENGTH));
  assign out_free  = !m_tvalid || m_tready;
  assign last_k    = IW'(cur_len - LW'(1));
  assign best_base = IW'(cur_len - LW'(2));
  assign rd_best_addr = best_base - k;
  assign wr_addr   = (state == rcm_pkg::ST_IDLE) ? IW'(count) : last_k;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath controls
  always_comb begin
    state_next = state;
    ctl        = '0;
    s_tready   = 1'b0;
    case (state)
      rcm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.clear_acc = 1'b1;
          ctl.price_we  = !full;
          state_next    = full ? rcm_pkg::ST_FINISH : rcm_pkg::ST_CALC;
        end
      end
      rcm_pkg::ST_CALC: begin
        ctl.rd_en = 1'b1;
        ctl.zero  = (k == last_k);
        if (k == last_k) begin
          state_next = rcm_pkg::ST_DRAIN;
        end
      end
      rcm_pkg::ST_DRAIN: begin
        state_next = rcm_pkg::ST_FINISH;
      end
      rcm_pkg::ST_FINISH: begin
        if (out_free) begin
          ctl.best_we = !ovf;
          state_next  = rcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rcm_pkg::ST_IDLE;
      end
    endcase
  end

  // Length counter, cut index and transaction flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cur_len <= '0;
      k       <= '0;
      ovf     <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (accept) begin
        ovf  <= full;
        done <= s_tlast;
        k    <= '0;
        if (!full) begin
          cur_len <= count + LW'(1);
          count   <= count + LW'(1);
        end
        if (s_tlast) begin
          count <= '0;
        end
      end else if (state == rcm_pkg::ST_CALC) begin
        k <= k + IW'(1);
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if ((state == rcm_pkg::ST_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if ((state == rcm_pkg::ST_FINISH) && out_free) begin
      if (ovf) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {3'b000, rcm_pkg::LEN_OUT_W'(cur_len), best};
      end
      m_tlast <= done;
      m_tuser <= ovf;
    end
  end

  rcm_engine #(
    .MAX_LENGTH (MAX_LENGTH),
    .PRICE_BITS (PRICE_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .price_in      (s_tdata),
    .wr_addr       (wr_addr),
    .rd_price_addr (k),
    .rd_best_addr  (rd_best_addr),
    .best_out      (best)
  );

endmodule

/* hdl/rcm_engine.sv */
// ----------------------------------------------------------------------------
// rcm_engine
// Price and best-revenue stores with a running maximum over the cut candidates.
// ----------------------------------------------------------------------------
module rcm_engine #(
  parameter int MAX_LENGTH = rcm_pkg::DEF_MAX_LENGTH,
  parameter int PRICE_BITS = rcm_pkg::DEF_PRICE_BITS,
  localparam int IW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rcm_pkg::rcm_ctl_t          ctl,
  input  logic [rcm_pkg::PRICE_W-1:0] price_in,
  input  logic [IW-1:0]              wr_addr,
  input  logic [IW-1:0]              rd_price_addr,
  input  logic [IW-1:0]              rd_best_addr,
  output logic [rcm_pkg::BEST_W-1:0] best_out
);

  localparam int PW = (PRICE_BITS < rcm_pkg::PRICE_W) ? PRICE_BITS : rcm_pkg::PRICE_W;

  logic [PW-1:0]              price_mem [MAX_LENGTH];
  logic [rcm_pkg::BEST_W-1:0] best_mem  [MAX_LENGTH];

  logic [PW-1:0]              price_q;
  logic [rcm_pkg::BEST_W-1:0] best_q;
  logic                       rd_vld;
  logic                       rd_zero;
  logic [rcm_pkg::ACC_W-1:0]  acc;
  logic [rcm_pkg::ACC_W-1:0]  cand;

  // Write and read both stores
  always_ff @(posedge clk) begin
    if (ctl.price_we) begin
      price_mem[wr_addr] <= price_in[PW-1:0];
    end
    if (ctl.best_we) begin
      best_mem[wr_addr] <= best_out;
    end
    if (ctl.rd_en) begin
      price_q <= price_mem[rd_price_addr];
      best_q  <= best_mem[rd_best_addr];
    end
  end

  // Track read data in the cycle after the read request
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      rd_zero <= 1'b0;
    end else begin
      rd_vld  <= ctl.rd_en;
      rd_zero <= ctl.zero;
    end
  end

  // Candidate revenue of one cut
  assign cand = rcm_pkg::ACC_W'(price_q)
              + (rd_zero ? '0 : rcm_pkg::ACC_W'(best_q));

  // Keep the running maximum
  always_ff @(posedge clk) begin
    if (ctl.clear_acc) begin
      acc <= '0;
    end else if (rd_vld && (cand > acc)) begin
      acc <= cand;
    end
  end

  // Saturate before store and output
  assign best_out = (acc > rcm_pkg::ACC_W'(rcm_pkg::BEST_LIMIT)) ? rcm_pkg::BEST_LIMIT
                                                                 : acc[rcm_pkg::BEST_W-1:0];

endmodule

/* hdl/rcm_checker.sv */
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level checks of the rod cutting revenue engine, bound to the top level.
// ----------------------------------------------------------------------------
module rcm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("stalled result changed");

  // Ignored price reports no length and no revenue
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[28:0] == 29'd0))
    else $error("ignored price carries data");

  // One transaction at a time: ready drops after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // Fill bits stay zero
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:29] == 3'd0))
    else $error("fill bits set");

endmodule

bind rod_cutting_max_revenue rcm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

/* bench/rod_cutting_max_revenue_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rod_cutting_max_revenue_test
// Self-checking bench for the rod cutting revenue engine. A short table of
// hand-picked prices comes first, then random problems of mixed length,
// including full-length rods and runs past the length limit. Each price
// transaction is predicted in the bench, and each result transaction is
// checked field by field against the oldest pending prediction. Both stream
// sides idle at random, and once the result side holds off long enough to
// back up the price side.
// ----------------------------------------------------------------------------
module rod_cutting_max_revenue_test;

  localparam int RANDOM_PRICES = 1400;
  localparam int HOLD_AT       = 150;   // result count that starts the long hold-off
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 200;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [rcm_pkg::BEST_W-1:0]    best;
    logic [rcm_pkg::LEN_OUT_W-1:0] len;
    logic                          done;
    logic                          ovf;
  } rod_result_t;

  typedef struct packed {
    logic [rcm_pkg::PRICE_W-1:0] price;
    logic                        last;
    logic [7:0]                  reps;
    logic                        typed;
    rod_result_t                 want;
  } price_row_t;

  localparam int PLAN_ROWS = 17;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // price[15:0]
  logic        s_tlast;   // last
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // best_revenue[21:0], rod_length[28:22], zero [31:29]
  logic        m_tlast;   // done_res
  logic        m_tuser;   // overflow

  // Bench copy of the stores and the length counter
  longint unsigned piece_price [rcm_pkg::DEF_MAX_LENGTH];
  longint unsigned rod_best    [rcm_pkg::DEF_MAX_LENGTH];
  int              rod_fill;

  rod_result_t pending_revenue [$];

  int mismatch_count;
  int result_count;
  int price_count;
  int problem_count;
  int ignored_count;
  int full_rod_count;

  // Directed prices: single-length problems, the textbook price list,
  // a full rod of top prices and the prices that arrive past the limit
  price_row_t plan [PLAN_ROWS] = '{
    '{16'd7,    1'b1, 8'd1,  1'b1, '{22'd7,     7'd1, 1'b1, 1'b0}},
    '{16'd0,    1'b1, 8'd1,  1'b1, '{22'd0,     7'd1, 1'b1, 1'b0}},
    '{16'hFFFF, 1'b1, 8'd1,  1'b1, '{22'd65535, 7'd1, 1'b1, 1'b0}},
    '{16'd1,    1'b0, 8'd1,  1'b0, '0},
    '{16'd5,    1'b0, 8'd1,  1'b0, '0},
    '{16'd8,    1'b0, 8'd1,  1'b0, '0},
    '{16'd9,    1'b0, 8'd1,  1'b0, '0},
    '{16'd10,   1'b0, 8'd1,  1'b0, '0},
    '{16'd17,   1'b0, 8'd1,  1'b0, '0},
    '{16'd17,   1'b0, 8'd1,  1'b0, '0},
    '{16'd20,   1'b1, 8'd1,  1'b0, '0},
    '{16'hFFFF, 1'b0, 8'd64, 1'b0, '0},
    '{16'h1234, 1'b0, 8'd1,  1'b1, '{22'd0,     7'd0, 1'b0, 1'b1}},
    '{16'hFFFF, 1'b1, 8'd1,  1'b1, '{22'd0,     7'd0, 1'b1, 1'b1}},
    '{16'd3,    1'b1, 8'd1,  1'b1, '{22'd3,     7'd1, 1'b1, 1'b0}},
    '{16'hAAAA, 1'b0, 8'd1,  1'b0, '0},
    '{16'h5555, 1'b1, 8'd1,  1'b0, '0}
  };

  rod_cutting_max_revenue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Best revenue of the next length, or the ignored-price result past the limit
  function automatic rod_result_t cut_rod(input logic [rcm_pkg::PRICE_W-1:0] p,
                                          input logic l);
    rod_result_t     r;
    longint unsigned pmask;
    longint unsigned cand;
    longint unsigned top;
    longint unsigned rest;
    int              len;
    pmask  = (64'd1 << rcm_pkg::DEF_PRICE_BITS) - 64'd1;
    r      = '0;
    r.done = l;
    if (rod_fill >= rcm_pkg::DEF_MAX_LENGTH) begin
      r.ovf = 1'b1;
    end else begin
      len = rod_fill + 1;
      piece_price[len-1] = longint'(p) & pmask;
      top = 0;
      for (int j = 1; j <= len; j++) begin
        rest = (len == j) ? 64'd0 : rod_best[len-j-1];
        cand = piece_price[j-1] + rest;
        if (cand > top) top = cand;
      end
      if (top > longint'(rcm_pkg::BEST_LIMIT)) top = longint'(rcm_pkg::BEST_LIMIT);
      rod_best[len-1] = top;
      rod_fill = len;
      r.best = top[rcm_pkg::BEST_W-1:0];
      r.len  = len[rcm_pkg::LEN_OUT_W-1:0];
    end
    if (l) rod_fill = 0;
    return r;
  endfunction

  // Idle cycles before a transaction; every fourth stretch of 97 runs back to back
  function automatic int idle_gap(input int n);
    if ((n / 97) % 4 == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Offer one price, wait for its acceptance and queue its expected result
  task automatic push_price(input logic [rcm_pkg::PRICE_W-1:0] p, input logic l,
                            input logic typed, input rod_result_t want);
    int          gap;
    rod_result_t predicted;
    gap = idle_gap(price_count);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = cut_rod(p, l);
    pending_revenue.push_back(typed ? want : predicted);
    price_count++;
    if (l) problem_count++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset and initial input levels
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Run limit
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // Accept and check result transactions
  initial begin : result_side
    int          stall;
    rod_result_t got;
    rod_result_t want;
    do @(posedge clk); while (rst);
    forever begin
      stall = idle_gap(result_count + 40);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.best = m_tdata[rcm_pkg::BEST_W-1:0];
      got.len  = m_tdata[rcm_pkg::BEST_W+rcm_pkg::LEN_OUT_W-1:rcm_pkg::BEST_W];
      got.done = m_tlast;
      got.ovf  = m_tuser;
      result_count++;
      if (got.ovf) ignored_count++;
      if (!got.ovf && int'(got.len) == rcm_pkg::DEF_MAX_LENGTH) full_rod_count++;
      if (pending_revenue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result %0d arrived with nothing pending: data %h last %b user %b",
                   result_count, m_tdata, m_tlast, m_tuser);
      end else begin
        want = pending_revenue.pop_front();
        if (got != want || m_tdata[31:rcm_pkg::BEST_W+rcm_pkg::LEN_OUT_W] != '0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"result %0d: expected best %0d len %0d done %b ovf %b, ",
                      "got best %0d len %0d done %b ovf %b pad %b"},
                     result_count, want.best, want.len, want.done, want.ovf,
                     got.best, got.len, got.done, got.ovf,
                     m_tdata[31:rcm_pkg::BEST_W+rcm_pkg::LEN_OUT_W]);
        end
      end
      // Hold off once for a long stretch so the engine backs up its input
      if (result_count == HOLD_AT) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Price stimulus, drain and verdict
  initial begin : price_side
    int                          rod_len;
    int                          pick;
    int                          random_sent;
    logic                        end_now;
    logic [rcm_pkg::PRICE_W-1:0] p;
    mismatch_count = 0;
    result_count   = 0;
    price_count    = 0;
    problem_count  = 0;
    ignored_count  = 0;
    full_rod_count = 0;
    rod_fill       = 0;
    random_sent    = 0;
    do @(posedge clk); while (rst);

    // Walk the directed table
    for (int r = 0; r < PLAN_ROWS; r++) begin
      repeat (plan[r].reps)
        push_price(plan[r].price, plan[r].last, plan[r].typed, plan[r].want);
    end

    // Random problems, mostly short, some full length, some past the limit
    while (random_sent < RANDOM_PRICES) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      rod_len = $urandom_range(1, 8);
      else if (pick < 80) rod_len = $urandom_range(9, 40);
      else if (pick < 92) rod_len = $urandom_range(rcm_pkg::DEF_MAX_LENGTH - 1,
                                                   rcm_pkg::DEF_MAX_LENGTH);
      else                rod_len = $urandom_range(rcm_pkg::DEF_MAX_LENGTH + 1,
                                                   rcm_pkg::DEF_MAX_LENGTH + 4);
      for (int k = 1; k <= rod_len; k++) begin
        case ($urandom_range(0, 3))
          0: p = rcm_pkg::PRICE_W'($urandom_range(0, 15));
          1: p = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
          default: p = rcm_pkg::PRICE_W'($urandom);
        endcase
        // End early now and then to break up the sequence
        end_now = (k == rod_len) || ($urandom_range(0, 99) < 2);
        push_price(p, end_now, 1'b0, '0);
        random_sent++;
        if (end_now) break;
      end
    end
    s_tvalid <= 1'b0;

    // Wait out every pending result, then watch for strays
    while (pending_revenue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d prices in %0d problems, %0d results checked.",
             price_count, problem_count, result_count);
    $display("Of those, %0d full-length rods and %0d prices ignored past the limit.",
             full_rod_count, ignored_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rcm_pkg.sv
hdl/rcm_engine.sv
hdl/rod_cutting_max_revenue.sv
hdl/rcm_checker.sv
bench/rod_cutting_max_revenue_test.sv
